@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the speed regulator.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ptbsc_pkg.sv @@
// Package of the speed regulator: field widths, event kinds, register map,
// reset values, sequencer states and the clamp helper. No dependencies.
package ptbsc_pkg;

    localparam int SPEED_W = 16;
    localparam int FUNC_W  = 2;
    localparam int REG_W   = 16;
    localparam int TMO_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Event kinds carried in the input tuser
    localparam logic [FUNC_W-1:0] FUNC_TARGET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MEAS   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_MAX_THROTTLE  = 3'd0;
    localparam logic [2:0] REG_MAX_BRAKE     = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
    localparam logic [2:0] REG_INTEG_GAIN    = 3'd3;
    localparam logic [2:0] REG_BRAKE_GAIN    = 3'd4;
    localparam logic [2:0] REG_TICK_PERIOD   = 3'd5;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd6;

    localparam logic [REG_W-1:0] RST_MAX_THROTTLE  = 16'd32768;
    localparam logic [REG_W-1:0] RST_MAX_BRAKE     = 16'd5000;
    localparam logic [REG_W-1:0] RST_PROP_GAIN     = 16'd1638;
    localparam logic [REG_W-1:0] RST_INTEG_GAIN    = 16'd410;
    localparam logic [REG_W-1:0] RST_BRAKE_GAIN    = 16'd3000;
    localparam logic [REG_W-1:0] RST_TICK_PERIOD   = 16'd1311;
    localparam logic [TMO_W-1:0] RST_TIMEOUT_TICKS = 8'd12;
    localparam logic [TMO_W-1:0] TICKS_SAT         = 8'hFF;

    // Bit-serial multiplier run lengths
    localparam logic [5:0] MUL_SHORT = 6'd16;
    localparam logic [5:0] MUL_LONG  = 6'd32;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DK    = 7'b0000010,
        ST_INC   = 7'b0000100,
        ST_PROP  = 7'b0001000,
        ST_INTEG = 7'b0010000,
        ST_BRAKE = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Clamp a signed value into [0, hi]
    function automatic logic [REG_W-1:0] clamp_hi(input logic signed [29:0] v,
                                                  input logic [REG_W-1:0] hi);
        logic signed [29:0] hi_s;
        hi_s = signed'({14'b0, hi});
        if (v >= hi_s)
            return hi;
        else if (v < 30'sd0)
            return '0;
        else
            return v[REG_W-1:0];
    endfunction

endpackage

@@ hdl/pi_throttle_brake_speed_control.sv @@
// Speed regulator top level: PI throttle and brake; uses ptbsc_pkg and assert_macros.svh.
// Target and measurement words give no result. A stale tick goes straight to the output
// stage; a fresh one runs five bit-serial products in turn (dt*ki, increment, proportional,
// integral, brake). One target/measurement word per cycle while the sequencer is idle; a
// tick holds off the input until its result is in the output register, longer while the
// output word waits. Reset (rst_n, async, low): defaults.
`include "assert_macros.svh"

module pi_throttle_brake_speed_control (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ptbsc_pkg::SPEED_W-1:0]     s_tdata,   // [15:0] speed
    input  logic [ptbsc_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2*ptbsc_pkg::REG_W-1:0]     m_tdata,   // [15:0] throttle, [31:16] brake
    output logic [0:0]                        m_tuser,   // [0] brake_valid
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptbsc_pkg::ADDR_W-1:0]      paddr,
    input  logic [ptbsc_pkg::DATA_W-1:0]      pwdata,
    output logic [ptbsc_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);
    import ptbsc_pkg::*;

    // Configuration
    logic [REG_W-1:0] max_thr_reg, max_thr_next;
    logic [REG_W-1:0] max_brk_reg, max_brk_next;
    logic [REG_W-1:0] kp_reg, kp_next;
    logic [REG_W-1:0] ki_reg, ki_next;
    logic [REG_W-1:0] kb_reg, kb_next;
    logic [REG_W-1:0] dt_reg, dt_next;
    logic [TMO_W-1:0] tmo_reg, tmo_next;

    // Regulator state
    logic signed [SPEED_W-1:0] target_reg, target_next;
    logic signed [SPEED_W-1:0] meas_reg, meas_next;
    logic [REG_W-1:0]          integ_reg, integ_next;
    logic [TMO_W-1:0]          ticks_reg, ticks_next;
    logic                      seen_reg, seen_next;

    // Sequencer and working values
    state_t                    state_reg, state_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic signed [16:0]        err_reg, err_next;
    logic signed [28:0]        prop_reg, prop_next;
    logic [REG_W-1:0]          thr_reg, thr_next;
    logic [REG_W-1:0]          brk_reg, brk_next;
    logic                      bv_reg, bv_next;

    // Bit-serial multiplier: signed multiplicand, unsigned multiplier shifted out
    logic signed [16:0]        mc_reg, mc_next;
    logic [31:0]               mp_reg, mp_next;
    logic signed [17:0]        acc_hi_reg, acc_hi_next;
    logic [31:0]               acc_lo_reg, acc_lo_next;

    // Output register
    logic                      m_valid_reg, m_valid_next;
    logic [2*REG_W-1:0]        m_data_reg, m_data_next;
    logic                      m_user_reg, m_user_next;

    logic                      cfg_wr;
    logic [2:0]                cfg_idx;
    logic signed [17:0]        addend;
    logic signed [17:0]        mul_sum;
    logic [49:0]               prod_long;
    logic [33:0]               prod_short;
    logic [5:0]                mul_len;
    logic                      mul_active;
    logic                      mul_done;
    logic signed [28:0]        inc;
    logic signed [29:0]        integ_sum;
    logic [21:0]               iterm;
    logic signed [29:0]        thr_sum;
    logic signed [29:0]        brk_sum;
    logic [TMO_W-1:0]          ticks_inc;
    logic                      stale;
    logic signed [16:0]        err_now;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_THROTTLE:  prdata = {16'b0, max_thr_reg};
            REG_MAX_BRAKE:     prdata = {16'b0, max_brk_reg};
            REG_PROP_GAIN:     prdata = {16'b0, kp_reg};
            REG_INTEG_GAIN:    prdata = {16'b0, ki_reg};
            REG_BRAKE_GAIN:    prdata = {16'b0, kb_reg};
            REG_TICK_PERIOD:   prdata = {16'b0, dt_reg};
            REG_TIMEOUT_TICKS: prdata = {24'b0, tmo_reg};
            default:           prdata = '0;
        endcase
    end

    // One shift-add step: add the multiplicand when the multiplier bit is set,
    // then shift the whole accumulator right by one
    assign addend     = mp_reg[0] ? {mc_reg[16], mc_reg} : 18'sd0;
    assign mul_sum    = acc_hi_reg + addend;
    assign prod_long  = {acc_hi_reg, acc_lo_reg};
    assign prod_short = {acc_hi_reg, acc_lo_reg[31:16]};
    assign mul_len    = (state_reg == ST_INC) ? MUL_LONG : MUL_SHORT;
    assign mul_active = !(state_reg == ST_IDLE || state_reg == ST_DONE);
    assign mul_done   = (cnt_reg == mul_len);

    assign inc       = prod_long[49:21];
    assign integ_sum = signed'({14'b0, integ_reg}) + {inc[28], inc};
    assign iterm     = prod_short[33:12];
    assign thr_sum   = {prop_reg[28], prop_reg} + signed'({8'b0, iterm});
    assign brk_sum   = {{4{prod_short[33]}}, prod_short[33:8]};

    assign ticks_inc = (ticks_reg == TICKS_SAT) ? ticks_reg : ticks_reg + 8'd1;
    assign stale     = !seen_reg || (ticks_inc > tmo_reg);
    assign err_now   = {target_reg[15], target_reg} - {meas_reg[15], meas_reg};

    always_comb
    begin
        max_thr_next = max_thr_reg;
        max_brk_next = max_brk_reg;
        kp_next      = kp_reg;
        ki_next      = ki_reg;
        kb_next      = kb_reg;
        dt_next      = dt_reg;
        tmo_next     = tmo_reg;
        target_next  = target_reg;
        meas_next    = meas_reg;
        integ_next   = integ_reg;
        ticks_next   = ticks_reg;
        seen_next    = seen_reg;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        prop_next    = prop_reg;
        thr_next     = thr_reg;
        brk_next     = brk_reg;
        bv_next      = bv_reg;
        mc_next      = mc_reg;
        mp_next      = mp_reg;
        acc_hi_next  = acc_hi_reg;
        acc_lo_next  = acc_lo_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAX_THROTTLE:  max_thr_next = pwdata[REG_W-1:0];
                REG_MAX_BRAKE:     max_brk_next = pwdata[REG_W-1:0];
                REG_PROP_GAIN:     kp_next      = pwdata[REG_W-1:0];
                REG_INTEG_GAIN:    ki_next      = pwdata[REG_W-1:0];
                REG_BRAKE_GAIN:    kb_next      = pwdata[REG_W-1:0];
                REG_TICK_PERIOD:   dt_next      = pwdata[REG_W-1:0];
                REG_TIMEOUT_TICKS: tmo_next     = pwdata[TMO_W-1:0];
                default:           ;
            endcase
        end

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        if (mul_active && !mul_done)
        begin
            acc_hi_next = {mul_sum[17], mul_sum[17:1]};
            acc_lo_next = {mul_sum[0], acc_lo_reg[31:1]};
            mp_next     = mp_reg >> 1;
            cnt_next    = cnt_reg + 6'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (s_tuser)
                        FUNC_TARGET:
                        begin
                            target_next = s_tdata;
                            ticks_next  = '0;
                            seen_next   = 1'b1;
                        end
                        FUNC_MEAS:
                            meas_next = s_tdata;
                        FUNC_TICK:
                        begin
                            ticks_next = ticks_inc;
                            if (stale)
                            begin
                                thr_next   = '0;
                                brk_next   = '0;
                                bv_next    = 1'b0;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                err_next    = err_now;
                                mc_next     = {1'b0, dt_reg};
                                mp_next     = {16'b0, ki_reg};
                                acc_hi_next = '0;
                                acc_lo_next = '0;
                                cnt_next    = '0;
                                state_next  = ST_DK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DK:
            begin
                // dt * ki becomes the 32-bit multiplier of the increment
                if (mul_done)
                begin
                    mc_next     = err_reg;
                    mp_next     = prod_short[31:0];
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    cnt_next    = '0;
                    state_next  = ST_INC;
                end
            end
            ST_INC:
            begin
                if (mul_done)
                begin
                    integ_next  = clamp_hi(integ_sum, max_thr_reg);
                    mc_next     = err_reg;
                    mp_next     = {16'b0, kp_reg};
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    cnt_next    = '0;
                    state_next  = ST_PROP;
                end
            end
            ST_PROP:
            begin
                if (mul_done)
                begin
                    prop_next   = prod_short[33:5];
                    mc_next     = {1'b0, integ_reg};
                    mp_next     = {16'b0, ki_reg};
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    cnt_next    = '0;
                    state_next  = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                // brake uses the negated error so the floor shift rounds as required
                if (mul_done)
                begin
                    thr_next    = clamp_hi(thr_sum, max_thr_reg);
                    mc_next     = 17'(-err_reg);
                    mp_next     = {16'b0, kb_reg};
                    acc_hi_next = '0;
                    acc_lo_next = '0;
                    cnt_next    = '0;
                    state_next  = ST_BRAKE;
                end
            end
            ST_BRAKE:
            begin
                if (mul_done)
                begin
                    brk_next   = clamp_hi(brk_sum, max_brk_reg);
                    bv_next    = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {brk_reg, thr_reg};
                    m_user_next  = bv_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_thr_reg <= RST_MAX_THROTTLE;
            max_brk_reg <= RST_MAX_BRAKE;
            kp_reg      <= RST_PROP_GAIN;
            ki_reg      <= RST_INTEG_GAIN;
            kb_reg      <= RST_BRAKE_GAIN;
            dt_reg      <= RST_TICK_PERIOD;
            tmo_reg     <= RST_TIMEOUT_TICKS;
            target_reg  <= '0;
            meas_reg    <= '0;
            integ_reg   <= '0;
            ticks_reg   <= TICKS_SAT;
            seen_reg    <= 1'b0;
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            max_thr_reg <= max_thr_next;
            max_brk_reg <= max_brk_next;
            kp_reg      <= kp_next;
            ki_reg      <= ki_next;
            kb_reg      <= kb_next;
            dt_reg      <= dt_next;
            tmo_reg     <= tmo_next;
            target_reg  <= target_next;
            meas_reg    <= meas_next;
            integ_reg   <= integ_next;
            ticks_reg   <= ticks_next;
            seen_reg    <= seen_next;
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg    <= err_next;
        prop_reg   <= prop_next;
        thr_reg    <= thr_next;
        brk_reg    <= brk_next;
        bv_reg     <= bv_next;
        mc_reg     <= mc_next;
        mp_reg     <= mp_next;
        acc_hi_reg <= acc_hi_next;
        acc_lo_reg <= acc_lo_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    `ASSERT_NEXT(a_tick_leaves_idle, s_tvalid && s_tready && s_tuser == FUNC_TICK, state_reg != ST_IDLE, "tick word did not start the sequencer")
    `ASSERT_IMPLIES(a_stale_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "stale tick gave a nonzero result")
    `ASSERT_IMPLIES(a_cnt_bound, mul_active, cnt_reg <= MUL_LONG, "multiplier step count overran")

endmodule

@@ tb/sv/tb_pi_throttle_brake_speed_control.sv @@
// Self-checking bench for the PI throttle and brake speed regulator: drives
// target, measurement and tick words, predicts each tick's result and compares.
// Depends on ptbsc_pkg and the pi_throttle_brake_speed_control RTL.
`timescale 1ns / 100ps

module tb_pi_throttle_brake_speed_control;
    import ptbsc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0]        REG_NONE    = 3'd7;
    localparam int                HOLD_CYCLES = 600;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [SPEED_W-1:0] speed;
    } speed_evt_t;

    typedef struct packed {
        logic [REG_W-1:0] throttle;
        logic [REG_W-1:0] brake;
        logic             brake_valid;
    } ctrl_out_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [SPEED_W-1:0]      s_tdata = '0;   // [15:0] speed
    logic [FUNC_W-1:0]       s_tuser = '0;   // [1:0] func
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [2*REG_W-1:0]      m_tdata;        // [15:0] throttle, [31:16] brake
    logic [0:0]              m_tuser;        // [0] brake_valid
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]       pwdata = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    // Regulator state and registers as the bench sees them
    logic [REG_W-1:0]          cfg_max_thr   = RST_MAX_THROTTLE;
    logic [REG_W-1:0]          cfg_max_brk   = RST_MAX_BRAKE;
    logic [REG_W-1:0]          cfg_prop      = RST_PROP_GAIN;
    logic [REG_W-1:0]          cfg_integ     = RST_INTEG_GAIN;
    logic [REG_W-1:0]          cfg_brk_gain  = RST_BRAKE_GAIN;
    logic [REG_W-1:0]          cfg_period    = RST_TICK_PERIOD;
    logic [TMO_W-1:0]          cfg_timeout   = RST_TIMEOUT_TICKS;
    logic signed [SPEED_W-1:0] set_speed     = '0;
    logic signed [SPEED_W-1:0] meas_speed    = '0;
    logic [REG_W-1:0]          integ_acc     = '0;
    logic [TMO_W-1:0]          ticks_since   = TICKS_SAT;
    logic                      set_seen      = 1'b0;

    speed_evt_t  speed_words[$];
    ctrl_out_t   ctrl_expected[$];
    logic        in_taken = 1'b0;
    logic        no_idle = 1'b0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    logic signed [SPEED_W-1:0] gen_target = '0;

    pi_throttle_brake_speed_control DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("FAIL pi_throttle_brake_speed_control");
        $finish;
    end

    function automatic longint clamp_to(input longint v, input longint hi);
        if (v >= hi)
            return hi;
        if (v < 0)
            return 0;
        return v;
    endfunction

    // Advance the regulator by one word; return 1 when a result is due
    function automatic bit regulate(input speed_evt_t w, output ctrl_out_t r);
        longint err;
        longint dk;
        longint integ;
        longint thr;
        longint brk;
        r = '0;
        if (w.func == FUNC_TARGET)
        begin
            set_speed   = w.speed;
            ticks_since = '0;
            set_seen    = 1'b1;
            return 1'b0;
        end
        if (w.func == FUNC_MEAS)
        begin
            meas_speed = w.speed;
            return 1'b0;
        end
        if (w.func != FUNC_TICK)
            return 1'b0;
        if (ticks_since != TICKS_SAT)
            ticks_since = ticks_since + 8'd1;
        if (!set_seen || ticks_since > cfg_timeout)
            return 1'b1;
        err   = longint'(set_speed) - longint'(meas_speed);
        dk    = longint'(cfg_period) * longint'(cfg_integ);
        integ = clamp_to(longint'(integ_acc) + ((dk * err) >>> 21), longint'(cfg_max_thr));
        integ_acc = integ[REG_W-1:0];
        thr = ((longint'(cfg_prop) * err) >>> 5) + ((longint'(cfg_integ) * integ) >>> 12);
        thr = clamp_to(thr, longint'(cfg_max_thr));
        brk = (-(longint'(cfg_brk_gain) * err)) >>> 8;
        brk = clamp_to(brk, longint'(cfg_max_brk));
        r.throttle    = thr[REG_W-1:0];
        r.brake       = brk[REG_W-1:0];
        r.brake_valid = 1'b1;
        return 1'b1;
    endfunction

    // Sender: offer the next queued word once the current one has gone
    always @(negedge clk)
    begin : drive_words
        speed_evt_t nxt;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (speed_words.size() != 0 && (no_idle || $urandom_range(99) >= 23))
            begin
                nxt = speed_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.speed;
                s_tuser  <= nxt.func;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 23);
    end

    // Check results first, then predict from the word taken at this edge
    always @(posedge clk)
    begin : watch_words
        ctrl_out_t  want;
        ctrl_out_t  got;
        speed_evt_t w;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got.throttle    = m_tdata[REG_W-1:0];
                got.brake       = m_tdata[2*REG_W-1:REG_W];
                got.brake_valid = m_tuser[0];
                if (ctrl_expected.size() == 0)
                begin
                    $error("result with none expected: throttle %0d brake %0d valid %0d",
                           got.throttle, got.brake, got.brake_valid);
                    mismatches++;
                end
                else
                begin
                    want = ctrl_expected.pop_front();
                    if (got.throttle !== want.throttle)
                    begin
                        $error("throttle expected %0d got %0d", want.throttle, got.throttle);
                        mismatches++;
                    end
                    if (got.brake !== want.brake)
                    begin
                        $error("brake expected %0d got %0d", want.brake, got.brake);
                        mismatches++;
                    end
                    if (got.brake_valid !== want.brake_valid)
                    begin
                        $error("brake_valid expected %0d got %0d",
                               want.brake_valid, got.brake_valid);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                w.func  = s_tuser;
                w.speed = s_tdata;
                if (regulate(w, want))
                    ctrl_expected.push_back(want);
            end
        end
    end

    task automatic push_word(input logic [FUNC_W-1:0] func, input logic [SPEED_W-1:0] spd);
        speed_evt_t w;
        w.func  = func;
        w.speed = spd;
        speed_words.push_back(w);
    endtask

    // Mostly target/measurement/tick traffic; speeds near the current target, extremes or random
    task automatic push_random(input int n);
        int                        kind;
        int                        pick;
        logic signed [SPEED_W-1:0] spd;
        logic [FUNC_W-1:0]         func;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            pick = $urandom_range(9);
            if (pick == 0)
                case ($urandom_range(3))
                    0: spd = 16'sh8000;
                    1: spd = 16'sh7FFF;
                    2: spd = 16'sh0000;
                    default: spd = 16'shFFFF;
                endcase
            else if (pick < 5)
                spd = gen_target + $signed(16'($urandom_range(512))) - 16'sd256;
            else
                spd = 16'($urandom());
            if (kind < 22)
            begin
                func = FUNC_TARGET;
                gen_target = spd;
            end
            else if (kind < 52)
                func = FUNC_MEAS;
            else if (kind < 95)
                func = FUNC_TICK;
            else
                func = FUNC_UNUSED;
            push_word(func, spd);
        end
    endtask

    // Hold until every word is taken and every result has come, then settle
    task automatic wait_idle();
        while (speed_words.size() != 0 || s_tvalid || ctrl_expected.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_MAX_THROTTLE:  cfg_max_thr  = val;
            REG_MAX_BRAKE:     cfg_max_brk  = val;
            REG_PROP_GAIN:     cfg_prop     = val;
            REG_INTEG_GAIN:    cfg_integ    = val;
            REG_BRAKE_GAIN:    cfg_brk_gain = val;
            REG_TICK_PERIOD:   cfg_period   = val;
            REG_TIMEOUT_TICKS: cfg_timeout  = val[TMO_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [REG_W-1:0] max_thr, input logic [REG_W-1:0] max_brk,
                              input logic [REG_W-1:0] prop, input logic [REG_W-1:0] integ,
                              input logic [REG_W-1:0] brk_gain, input logic [REG_W-1:0] period,
                              input logic [TMO_W-1:0] timeout);
        write_reg(REG_MAX_THROTTLE, max_thr);
        write_reg(REG_MAX_BRAKE, max_brk);
        write_reg(REG_PROP_GAIN, prop);
        write_reg(REG_INTEG_GAIN, integ);
        write_reg(REG_BRAKE_GAIN, brk_gain);
        write_reg(REG_TICK_PERIOD, period);
        write_reg(REG_TIMEOUT_TICKS, {8'd0, timeout});
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: stale before any target, unused kind, both extremes, zero error,
        // then a target aged through the default timeout
        push_word(FUNC_TICK, 16'h0000);
        push_word(FUNC_UNUSED, 16'hFFFF);
        push_word(FUNC_MEAS, 16'h8000);
        push_word(FUNC_TARGET, 16'h7FFF);
        push_word(FUNC_TICK, 16'h0000);
        push_word(FUNC_MEAS, 16'h7FFF);
        push_word(FUNC_TARGET, 16'h8000);
        push_word(FUNC_TICK, 16'hFFFF);
        push_word(FUNC_MEAS, 16'h0100);
        push_word(FUNC_TARGET, 16'h0100);
        push_word(FUNC_TICK, 16'h0000);
        push_word(FUNC_TARGET, 16'h0200);
        for (int i = 0; i < 13; i++)
            push_word(FUNC_TICK, 16'h0000);
        gen_target = 16'sh0200;
        wait_idle();

        // Defaults, with the receiver held off while the sender keeps offering
        push_random(300);
        hold_go = 1'b1;
        wait_idle();

        // Everything zero: every tick stale
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        push_random(100);
        wait_idle();

        // Everything at its maximum; a seen target must never go stale
        set_config(16'd32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
        no_idle = 1'b1;
        push_word(FUNC_TARGET, 16'h0080);
        push_word(FUNC_MEAS, 16'h0000);
        for (int i = 0; i < 270; i++)
            push_word(FUNC_TICK, 16'($urandom()));
        push_random(30);
        wait_idle();
        no_idle = 1'b0;

        write_reg(REG_NONE, 16'($urandom()));
        for (int p = 0; p < 5; p++)
        begin
            set_config(($urandom_range(3) == 0) ? 16'd32768 : 16'($urandom_range(32768)),
                       16'($urandom()),
                       16'($urandom_range(($urandom_range(1) != 0) ? 8191 : 65535)),
                       16'($urandom_range(($urandom_range(1) != 0) ? 4095 : 65535)),
                       16'($urandom()),
                       16'($urandom()),
                       ($urandom_range(4) == 0) ? 8'd254 : 8'($urandom_range(1, 20)));
            push_random(100);
            wait_idle();
            push_random(100);
            wait_idle();
        end

        repeat (120) @(posedge clk);
        if (mismatches == 0)
            $display("PASS pi_throttle_brake_speed_control");
        else
            $display("FAIL pi_throttle_brake_speed_control");
        $finish;
    end

endmodule
